[rtl/dps_pkg.sv]
// Shared constants and types for the data-processing ALU and barrel shifter.
`default_nettype none
package dps_pkg;

   localparam logic [31:0] StatusReset = 32'h0000_00D3;

   // PSR bit positions
   localparam int FlagN = 31;
   localparam int FlagZ = 30;
   localparam int FlagC = 29;
   localparam int FlagV = 28;
   localparam int BitT  = 5;

   localparam logic [3:0] RegPc = 4'hF;

   // ALU opcodes
   localparam logic [3:0] OpAnd = 4'h0;
   localparam logic [3:0] OpEor = 4'h1;
   localparam logic [3:0] OpSub = 4'h2;
   localparam logic [3:0] OpRsb = 4'h3;
   localparam logic [3:0] OpAdd = 4'h4;
   localparam logic [3:0] OpAdc = 4'h5;
   localparam logic [3:0] OpSbc = 4'h6;
   localparam logic [3:0] OpRsc = 4'h7;
   localparam logic [3:0] OpTst = 4'h8;
   localparam logic [3:0] OpTeq = 4'h9;
   localparam logic [3:0] OpCmp = 4'hA;
   localparam logic [3:0] OpCmn = 4'hB;
   localparam logic [3:0] OpOrr = 4'hC;
   localparam logic [3:0] OpMov = 4'hD;
   localparam logic [3:0] OpBic = 4'hE;
   localparam logic [3:0] OpMvn = 4'hF;

   // shift kinds
   localparam logic [1:0] ShLsl = 2'd0;
   localparam logic [1:0] ShLsr = 2'd1;
   localparam logic [1:0] ShAsr = 2'd2;
   localparam logic [1:0] ShRor = 2'd3;

   typedef struct packed {
      logic [31:0] value;
      logic        carry;
   } shift_out_type;

   typedef struct packed {
      logic [31:0] dest_value;
      logic        dest_write;
      logic [3:0]  dest_index;
      logic [31:0] status;
      logic        mode_switch;
   } result_type;

endpackage
`default_nettype wire

[rtl/dps_shifter.sv]
// Barrel shifter: forms operand 2 and the shifter carry.
`default_nettype none
module dps_shifter (
   input  wire logic [31:0]           instr,
   input  wire logic [31:0]           rm,
   input  wire logic [31:0]           rs,
   input  wire logic                  c_in,
   output dps_pkg::shift_out_type     shift_out
);

   function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] t;
      t = {v, v} >> n;
      return t[31:0];
   endfunction

   logic [1:0]         kind;
   logic [7:0]         amt;
   logic               imm_zero;
   logic               rrx;
   logic               big;
   logic               exact32;
   logic [4:0]         rot;
   logic [31:0]        rot_imm;
   logic [32:0]        lsl_w;
   logic [32:0]        lsr_w;
   logic signed [32:0] asr_w;
   logic [31:0]        ror_w;

   assign kind     = instr[6:5];
   assign imm_zero = !instr[4] && (instr[11:7] == 5'd0);
   assign rrx      = imm_zero && (kind == dps_pkg::ShRor);

   // immediate LSR #0 and ASR #0 stand for a shift by 32
   always_comb begin
      if (instr[4]) begin
         amt = rs[7:0];
      end else if (imm_zero && (kind == dps_pkg::ShLsr || kind == dps_pkg::ShAsr)) begin
         amt = 8'd32;
      end else begin
         amt = {3'd0, instr[11:7]};
      end
   end

   assign big     = (amt[7:5] != 3'd0);
   assign exact32 = (amt == 8'd32);
   assign lsl_w   = {1'b0, rm} << amt[4:0];
   assign lsr_w   = {rm, 1'b0} >> amt[4:0];
   assign asr_w   = $signed({rm, 1'b0}) >>> amt[4:0];
   assign ror_w   = ror32(rm, amt[4:0]);
   assign rot     = {instr[11:8], 1'b0};
   assign rot_imm = ror32({24'd0, instr[7:0]}, rot);

   always_comb begin
      shift_out.value = rm;
      shift_out.carry = c_in;
      if (instr[25]) begin
         shift_out.value = rot_imm;
         shift_out.carry = (rot == 5'd0) ? c_in : rot_imm[31];
      end else if (rrx) begin
         shift_out.value = {c_in, rm[31:1]};
         shift_out.carry = rm[0];
      end else if (amt != 8'd0) begin
         case (kind)
            dps_pkg::ShLsl: begin
               shift_out.value = big ? 32'd0 : lsl_w[31:0];
               shift_out.carry = big ? (exact32 && rm[0]) : lsl_w[32];
            end
            dps_pkg::ShLsr: begin
               shift_out.value = big ? 32'd0 : lsr_w[32:1];
               shift_out.carry = big ? (exact32 && rm[31]) : lsr_w[0];
            end
            dps_pkg::ShAsr: begin
               shift_out.value = big ? {32{rm[31]}} : asr_w[32:1];
               shift_out.carry = big ? rm[31] : asr_w[0];
            end
            default: begin
               shift_out.value = ror_w;
               shift_out.carry = ror_w[31];
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/dps_alu.sv]
// ALU, destination write and status update for one data-processing instruction.
`default_nettype none
module dps_alu (
   input  wire logic [31:0]           instr,
   input  wire logic [31:0]           rn,
   input  wire logic [31:0]           spsr,
   input  wire logic                  has_spsr,
   input  wire logic [31:0]           status,
   input  wire dps_pkg::shift_out_type shift_in,
   output dps_pkg::result_type        result
);

   logic [3:0]  opc;
   logic        s_bit;
   logic [3:0]  rd;
   logic [31:0] op2;
   logic [31:0] x;
   logic [31:0] y;
   logic        cin;
   logic [32:0] sum;
   logic [31:0] lres;
   logic [31:0] res;
   logic        logical;
   logic        wr;
   logic        ovf;
   logic        c_in;
   logic [31:0] st;

   assign opc   = instr[24:21];
   assign s_bit = instr[20];
   assign rd    = instr[15:12];
   assign op2   = shift_in.value;
   assign c_in  = status[dps_pkg::FlagC];

   always_comb begin
      x       = rn;
      y       = op2;
      cin     = 1'b0;
      lres    = rn & op2;
      logical = 1'b1;
      wr      = 1'b1;
      case (opc)
         dps_pkg::OpAnd: lres = rn & op2;
         dps_pkg::OpEor: lres = rn ^ op2;
         dps_pkg::OpSub: begin y = ~op2; cin = 1'b1; logical = 1'b0; end
         dps_pkg::OpRsb: begin x = op2; y = ~rn; cin = 1'b1; logical = 1'b0; end
         dps_pkg::OpAdd: logical = 1'b0;
         dps_pkg::OpAdc: begin cin = c_in; logical = 1'b0; end
         dps_pkg::OpSbc: begin y = ~op2; cin = c_in; logical = 1'b0; end
         dps_pkg::OpRsc: begin x = op2; y = ~rn; cin = c_in; logical = 1'b0; end
         dps_pkg::OpTst: begin lres = rn & op2; wr = 1'b0; end
         dps_pkg::OpTeq: begin lres = rn ^ op2; wr = 1'b0; end
         dps_pkg::OpCmp: begin y = ~op2; cin = 1'b1; logical = 1'b0; wr = 1'b0; end
         dps_pkg::OpCmn: begin logical = 1'b0; wr = 1'b0; end
         dps_pkg::OpOrr: lres = rn | op2;
         dps_pkg::OpMov: lres = op2;
         dps_pkg::OpBic: lres = rn & ~op2;
         default:        lres = ~op2;
      endcase
   end

   assign sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
   assign ovf = (x[31] == y[31]) && (sum[31] != x[31]);
   assign res = logical ? lres : sum[31:0];

   always_comb begin
      st = status;
      st[dps_pkg::FlagN] = res[31];
      st[dps_pkg::FlagZ] = (res == 32'd0);
      if (logical) begin
         st[dps_pkg::FlagC] = shift_in.carry;
      end else begin
         st[dps_pkg::FlagC] = sum[32];
         st[dps_pkg::FlagV] = ovf;
      end
   end

   always_comb begin
      result.dest_index  = rd;
      result.dest_write  = wr;
      result.mode_switch = 1'b0;
      result.status      = status;
      result.dest_value  = 32'd0;
      if (wr) begin
         result.dest_value = (rd == dps_pkg::RegPc) ? {res[31:2], 2'b00} : res;
      end
      if (s_bit) begin
         if (rd == dps_pkg::RegPc && wr) begin
            // exception return: copy SPSR, align PC by the new T bit
            if (has_spsr) begin
               result.status      = spsr;
               result.mode_switch = 1'b1;
               result.dest_value  = spsr[dps_pkg::BitT] ? {res[31:1], 1'b0}
                                                       : {res[31:2], 2'b00};
            end
         end else begin
            result.status = st;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/data_processing_alu_shifter.sv]
// Data-processing execute stage: input register, shifter and ALU, result register.
// An accepted req beat passes the input register, then the result register, to rsp_valid.
// Throughput: one instruction per cycle; the CPSR carry loops back through status_ff,
// and only a held rsp stage stalls the input.
// Reset (synchronous, active high): both stages empty, CPSR = 0x000000D3.
`default_nettype none
module data_processing_alu_shifter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr_word,
   input  wire logic [31:0] req_first_value,
   input  wire logic [31:0] req_shifted_value,
   input  wire logic [31:0] req_amount_value,
   input  wire logic [31:0] req_saved_status,
   input  wire logic        req_saved_present,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_dest_value,
   output logic             rsp_dest_write,
   output logic [3:0]       rsp_dest_index,
   output logic [31:0]      rsp_status_out,
   output logic             rsp_mode_switch
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [31:0]             instr_ff;
   logic [31:0]             first_ff;
   logic [31:0]             shifted_ff;
   logic [31:0]             amount_ff;
   logic [31:0]             saved_ff;
   logic                    present_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   dps_pkg::result_type     rsp_data_ff;
   logic [31:0]             status_ff;
   logic [31:0]             status_in;
   logic                    out_free;
   logic                    advance;
   logic                    load_in;
   dps_pkg::shift_out_type  shift_out;
   dps_pkg::result_type     alu_result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign load_in   = req_valid && !req_stall;

   assign in_valid_in  = load_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   assign status_in    = advance ? alu_result.status : status_ff;

   dps_shifter u_shifter (
      .instr     (instr_ff),
      .rm        (shifted_ff),
      .rs        (amount_ff),
      .c_in      (status_ff[dps_pkg::FlagC]),
      .shift_out (shift_out)
   );

   dps_alu u_alu (
      .instr    (instr_ff),
      .rn       (first_ff),
      .spsr     (saved_ff),
      .has_spsr (present_ff),
      .status   (status_ff),
      .shift_in (shift_out),
      .result   (alu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= dps_pkg::StatusReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   // capture a new beat; hold while stalled
   always_ff @(posedge clock) begin
      if (load_in) begin
         instr_ff   <= req_instr_word;
         first_ff   <= req_first_value;
         shifted_ff <= req_shifted_value;
         amount_ff  <= req_amount_value;
         saved_ff   <= req_saved_status;
         present_ff <= req_saved_present;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= alu_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dest_value  = rsp_data_ff.dest_value;
   assign rsp_dest_write  = rsp_data_ff.dest_write;
   assign rsp_dest_index  = rsp_data_ff.dest_index;
   assign rsp_status_out  = rsp_data_ff.status;
   assign rsp_mode_switch = rsp_data_ff.mode_switch;

   a_reset_state: assert property (@(posedge clock)
      reset |=> (status_ff == dps_pkg::StatusReset) && !rsp_valid_ff && !in_valid_ff)
      else $error("reset state wrong");

   a_status_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status == status_ff))
      else $error("CPSR differs from the pending result");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.dest_write) |-> (rsp_data_ff.dest_value == 32'd0))
      else $error("value present without a destination write");

   a_switch_pc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.mode_switch) |->
         (rsp_data_ff.dest_write && (rsp_data_ff.dest_index == dps_pkg::RegPc)))
      else $error("mode switch without a PC write");

endmodule
`default_nettype wire

[sim/tb_data_processing_alu_shifter.sv]
// Self-checking testbench for the data-processing ALU and barrel shifter.
module tb_data_processing_alu_shifter;

   localparam int CycleLimit  = 600000;
   localparam int ReportLimit = 40;
   localparam int RandomItems = 1120;
   localparam int PhaseItems  = 140;

   localparam logic [3:0] AllOps [16] = '{
      dps_pkg::OpAnd, dps_pkg::OpEor, dps_pkg::OpSub, dps_pkg::OpRsb,
      dps_pkg::OpAdd, dps_pkg::OpAdc, dps_pkg::OpSbc, dps_pkg::OpRsc,
      dps_pkg::OpTst, dps_pkg::OpTeq, dps_pkg::OpCmp, dps_pkg::OpCmn,
      dps_pkg::OpOrr, dps_pkg::OpMov, dps_pkg::OpBic, dps_pkg::OpMvn};

   // MSR-immediate encodings: fixed bits under the mask
   localparam logic [31:0] PsrXferMask = 32'h0FB0_F000;
   localparam logic [31:0] PsrXferBits = 32'h0320_F000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_instr_word;
   logic [31:0] req_first_value;
   logic [31:0] req_shifted_value;
   logic [31:0] req_amount_value;
   logic [31:0] req_saved_status;
   logic        req_saved_present;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_dest_value;
   logic        rsp_dest_write;
   logic [3:0]  rsp_dest_index;
   logic [31:0] rsp_status_out;
   logic        rsp_mode_switch;

   logic [31:0]          cpsr_shadow = dps_pkg::StatusReset;
   dps_pkg::result_type  predicted_retires [$];
   int                   error_count  = 0;
   int                   retire_count = 0;
   int                   cycle_count  = 0;
   bit                   gaps_on      = 1'b0;
   bit                   stalls_on    = 1'b0;

   data_processing_alu_shifter DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic dps_pkg::shift_out_type shift_by_amount(input logic [31:0] v,
                                                              input logic [1:0] kind,
                                                              input int amt);
      dps_pkg::shift_out_type so;
      logic [63:0]            twice;
      twice    = {v, v} >> (amt % 32);
      so.value = 32'h0;
      so.carry = 1'b0;
      case (kind)
         dps_pkg::ShLsl: begin
            if (amt < 32) begin
               so.value = v << amt;
               so.carry = v[32 - amt];
            end else if (amt == 32) so.carry = v[0];
         end
         dps_pkg::ShLsr: begin
            if (amt < 32) begin
               so.value = v >> amt;
               so.carry = v[amt - 1];
            end else if (amt == 32) so.carry = v[31];
         end
         dps_pkg::ShAsr: begin
            if (amt < 32) begin
               so.value = $signed(v) >>> amt;
               so.carry = v[amt - 1];
            end else begin
               so.value = {32{v[31]}};
               so.carry = v[31];
            end
         end
         default: begin
            so.value = twice[31:0];
            so.carry = twice[31];
         end
      endcase
      return so;
   endfunction

   // Execute one instruction against the shadow CPSR and return the retire beat.
   function automatic dps_pkg::result_type execute_dp(input logic [31:0] iw, rn, rm, rs, spsr,
                                                      input logic has_spsr);
      dps_pkg::result_type    r;
      dps_pkg::shift_out_type op2;
      logic [63:0]            twice;
      logic [32:0]            sum;
      logic [31:0]            a, b, res;
      logic [3:0]             opc;
      logic                   c_in, carry_in, arith, av;
      int                     rot;
      c_in = cpsr_shadow[dps_pkg::FlagC];
      if (iw[25]) begin
         rot       = int'({iw[11:8], 1'b0});
         twice     = {24'h0, iw[7:0], 24'h0, iw[7:0]} >> rot;
         op2.value = twice[31:0];
         op2.carry = (rot == 0) ? c_in : op2.value[31];
      end else if (iw[4]) begin
         if (rs[7:0] == 8'h00) begin
            op2.value = rm;
            op2.carry = c_in;
         end else op2 = shift_by_amount(rm, iw[6:5], int'(rs[7:0]));
      end else if (iw[11:7] != 5'd0) begin
         op2 = shift_by_amount(rm, iw[6:5], int'(iw[11:7]));
      end else begin
         // zero amount: LSL passes through, ROR is RRX, LSR and ASR mean 32
         case (iw[6:5])
            dps_pkg::ShLsl: begin
               op2.value = rm;
               op2.carry = c_in;
            end
            dps_pkg::ShRor: begin
               op2.value = {c_in, rm[31:1]};
               op2.carry = rm[0];
            end
            default: op2 = shift_by_amount(rm, iw[6:5], 32);
         endcase
      end

      opc      = iw[24:21];
      a        = rn;
      b        = op2.value;
      carry_in = 1'b0;
      arith    = 1'b1;
      res      = 32'h0;
      case (opc)
         dps_pkg::OpSub, dps_pkg::OpCmp: begin
            b        = ~op2.value;
            carry_in = 1'b1;
         end
         dps_pkg::OpRsb: begin
            a        = op2.value;
            b        = ~rn;
            carry_in = 1'b1;
         end
         dps_pkg::OpAdd, dps_pkg::OpCmn: carry_in = 1'b0;
         dps_pkg::OpAdc: carry_in = c_in;
         dps_pkg::OpSbc: begin
            b        = ~op2.value;
            carry_in = c_in;
         end
         dps_pkg::OpRsc: begin
            a        = op2.value;
            b        = ~rn;
            carry_in = c_in;
         end
         dps_pkg::OpAnd, dps_pkg::OpTst: begin
            arith = 1'b0;
            res   = rn & op2.value;
         end
         dps_pkg::OpEor, dps_pkg::OpTeq: begin
            arith = 1'b0;
            res   = rn ^ op2.value;
         end
         dps_pkg::OpOrr: begin
            arith = 1'b0;
            res   = rn | op2.value;
         end
         dps_pkg::OpMov: begin
            arith = 1'b0;
            res   = op2.value;
         end
         dps_pkg::OpBic: begin
            arith = 1'b0;
            res   = rn & ~op2.value;
         end
         default: begin
            arith = 1'b0;
            res   = ~op2.value;
         end
      endcase
      sum = {1'b0, a} + {1'b0, b} + {32'h0, carry_in};
      av  = (a[31] == b[31]) && (sum[31] != a[31]);
      if (arith) res = sum[31:0];

      r.dest_write  = !(opc inside {dps_pkg::OpTst, dps_pkg::OpTeq,
                                    dps_pkg::OpCmp, dps_pkg::OpCmn});
      r.dest_index  = iw[15:12];
      r.dest_value  = 32'h0;
      r.mode_switch = 1'b0;
      if (r.dest_write)
         r.dest_value = (r.dest_index == dps_pkg::RegPc) ? {res[31:2], 2'b00} : res;
      if (iw[20]) begin
         if (r.dest_index == dps_pkg::RegPc && r.dest_write) begin
            // exception return; without an SPSR the CPSR holds
            if (has_spsr) begin
               cpsr_shadow   = spsr;
               r.mode_switch = 1'b1;
               r.dest_value  = spsr[dps_pkg::BitT] ? {res[31:1], 1'b0} : {res[31:2], 2'b00};
            end
         end else begin
            cpsr_shadow[dps_pkg::FlagN] = res[31];
            cpsr_shadow[dps_pkg::FlagZ] = (res == 32'h0);
            if (arith) begin
               cpsr_shadow[dps_pkg::FlagC] = sum[32];
               cpsr_shadow[dps_pkg::FlagV] = av;
            end else cpsr_shadow[dps_pkg::FlagC] = op2.carry;
         end
      end
      r.status = cpsr_shadow;
      return r;
   endfunction

   // ---------------------------------------------------------------- encoding helpers

   function automatic logic [31:0] dp_word(input logic [3:0] opc, input logic s,
                                           input logic [3:0] rd, input logic imm,
                                           input logic [11:0] operand);
      logic [3:0] cond;
      cond = 4'($urandom_range(0, 15));
      return {cond, 2'b00, imm, opc, s, 4'h1, rd, operand};
   endfunction

   function automatic logic [11:0] imm_shift_field(input logic [4:0] amt, input logic [1:0] kind);
      return {amt, kind, 1'b0, 4'h2};
   endfunction

   function automatic logic [11:0] reg_shift_field(input logic [1:0] kind);
      return {4'h3, 1'b0, kind, 1'b1, 4'h2};
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_pause(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_item(input logic [31:0] iw, rn, rm, rs, spsr, input logic has_spsr);
      int gap;
      gap = pick_pause(gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_instr_word    <= iw;
      req_first_value   <= rn;
      req_shifted_value <= rm;
      req_amount_value  <= rs;
      req_saved_status  <= spsr;
      req_saved_present <= has_spsr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_retires.push_back(execute_dp(iw, rn, rm, rs, spsr, has_spsr));
   endtask

   // Drop valid and hold off until every predicted beat has retired.
   task automatic wait_for_retires();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_retires.size() != 0) @(posedge clock);
   endtask

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         hold = pick_pause(stalls_on);
         if (hold == 0) rsp_stall <= 1'b0;
         else begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < ReportLimit)
         $display("retire %0d: %s got %h, expected %h", retire_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      dps_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_retires.size() == 0) begin
            report_mismatch("beat with nothing pending, dest_value", rsp_dest_value, 32'h0);
         end else begin
            want = predicted_retires.pop_front();
            if (rsp_dest_value !== want.dest_value)
               report_mismatch("dest_value", rsp_dest_value, want.dest_value);
            if (rsp_dest_write !== want.dest_write)
               report_mismatch("dest_write", 32'(rsp_dest_write), 32'(want.dest_write));
            if (rsp_dest_index !== want.dest_index)
               report_mismatch("dest_index", 32'(rsp_dest_index), 32'(want.dest_index));
            if (rsp_status_out !== want.status)
               report_mismatch("status_out", rsp_status_out, want.status);
            if (rsp_mode_switch !== want.mode_switch)
               report_mismatch("mode_switch", 32'(rsp_mode_switch), 32'(want.mode_switch));
         end
         retire_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_immediate_operand();
      // rotation 0 keeps C; a nonzero rotation takes C from bit 31
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'h0, 1'b1, {4'h0, 8'h00}),
                32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'h2, 1'b1, {4'h1, 8'hFF}),
                32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpAnd, 1'b1, 4'h3, 1'b1, {4'h0, 8'h80}),
                32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
   endtask

   task automatic test_shift_by_immediate();
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'h4, 1'b0, imm_shift_field(5'd0, dps_pkg::ShLsl)),
                32'h0, 32'h8000_0001, 32'h0, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'h5, 1'b0, imm_shift_field(5'd0, dps_pkg::ShLsr)),
                32'h0, 32'h8000_0001, 32'h0, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'h6, 1'b0, imm_shift_field(5'd0, dps_pkg::ShAsr)),
                32'h0, 32'h8000_0001, 32'h0, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'h7, 1'b0, imm_shift_field(5'd0, dps_pkg::ShRor)),
                32'h0, 32'h8000_0001, 32'h0, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'h8, 1'b0, imm_shift_field(5'd31, dps_pkg::ShLsl)),
                32'h0, 32'h0000_0003, 32'h0, 32'h0, 1'b0);
   endtask

   task automatic test_shift_by_register();
      // low byte zero with upper bits set: pass Rm through, keep C
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'h9, 1'b0, reg_shift_field(dps_pkg::ShLsr)),
                32'h0, 32'h1234_5678, 32'hFFFF_FF00, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'hA, 1'b0, reg_shift_field(dps_pkg::ShLsl)),
                32'h0, 32'h0000_0001, 32'd32, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'hB, 1'b0, reg_shift_field(dps_pkg::ShLsr)),
                32'h0, 32'hFFFF_FFFF, 32'd33, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'hC, 1'b0, reg_shift_field(dps_pkg::ShAsr)),
                32'h0, 32'h8000_0000, 32'd255, 32'h0, 1'b0);
      send_item(dp_word(dps_pkg::OpMov, 1'b1, 4'hD, 1'b0, reg_shift_field(dps_pkg::ShRor)),
                32'h0, 32'h8000_0000, 32'd32, 32'h0, 1'b0);
   endtask

   task automatic test_alu_opcodes();
      logic [31:0] rn_corner [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      logic [31:0] rm_corner [4] = '{32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0};
      for (int i = 0; i < 16; i++)
         send_item(dp_word(AllOps[i], 1'b1, 4'(i % 15), 1'b0,
                           imm_shift_field(5'd0, dps_pkg::ShLsl)),
                   rn_corner[i % 4], rm_corner[(i / 4) % 4], 32'h0, 32'h0, 1'b0);
   endtask

   task automatic test_exception_return();
      // T set in the SPSR aligns the PC to 2 bytes, clear to 4
      send_item(dp_word(dps_pkg::OpMov, 1'b1, dps_pkg::RegPc, 1'b0,
                        imm_shift_field(5'd0, dps_pkg::ShLsl)),
                32'h0, 32'h0000_1003, 32'h0, 32'h6000_003F, 1'b1);
      send_item(dp_word(dps_pkg::OpSub, 1'b1, dps_pkg::RegPc, 1'b1, {4'h0, 8'h04}),
                32'h0000_2007, 32'h0, 32'h0, 32'h9000_0010, 1'b1);
      // no SPSR in this mode: CPSR holds
      send_item(dp_word(dps_pkg::OpMov, 1'b1, dps_pkg::RegPc, 1'b0,
                        imm_shift_field(5'd0, dps_pkg::ShLsl)),
                32'h0, 32'h0000_3003, 32'h0, 32'hF000_003F, 1'b0);
      send_item(dp_word(dps_pkg::OpAdd, 1'b0, dps_pkg::RegPc, 1'b1, {4'h0, 8'h07}),
                32'h0000_1000, 32'h0, 32'h0, 32'h0, 1'b1);
   endtask

   task automatic test_psr_transfer_words();
      logic [31:0] iw;
      iw = PsrXferBits | ($urandom & ~PsrXferMask);
      iw[22] = 1'b0;
      send_item(iw, $urandom, $urandom, $urandom, $urandom, 1'b1);
      iw = PsrXferBits | ($urandom & ~PsrXferMask);
      iw[22] = 1'b1;
      send_item(iw, $urandom, $urandom, $urandom, $urandom, 1'b0);
   endtask

   task automatic send_random_item();
      logic [31:0] iw, rs;
      iw = $urandom;
      if ($urandom_range(0, 9) != 0) begin
         iw[27:26] = 2'b00;
         if (iw[25] && $urandom_range(0, 3) == 0) iw[11:8] = 4'h0;
         if (!iw[25] && iw[4]) iw[7] = 1'b0;
         if (!iw[25] && !iw[4] && $urandom_range(0, 3) == 0) iw[11:7] = 5'd0;
         if ($urandom_range(0, 5) == 0) iw[15:12] = dps_pkg::RegPc;
      end else if ($urandom_range(0, 3) == 0) begin
         iw = PsrXferBits | (iw & ~PsrXferMask);
      end
      rs = $urandom;
      case ($urandom_range(0, 5))
         0: rs[7:0] = 8'd0;
         1: rs[7:0] = 8'd32;
         2: rs[7:0] = 8'($urandom_range(31, 34));
         3: rs[7:0] = 8'($urandom_range(1, 31));
         default: ;
      endcase
      send_item(iw, pick_word(), pick_word(), rs, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_random_stream();
      for (int phase = 0; phase < RandomItems / PhaseItems; phase++) begin
         // rotate idling: both sides, none, sender only, receiver only
         gaps_on   = (phase % 4 == 0) || (phase % 4 == 2);
         stalls_on = (phase % 4 == 0) || (phase % 4 == 3);
         repeat (PhaseItems) send_random_item();
         if (phase % 3 == 1) wait_for_retires();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_instr_word    <= 32'h0;
      req_first_value   <= 32'h0;
      req_shifted_value <= 32'h0;
      req_amount_value  <= 32'h0;
      req_saved_status  <= 32'h0;
      req_saved_present <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_immediate_operand();
      test_shift_by_immediate();
      stalls_on = 1'b1;
      test_shift_by_register();
      test_alu_opcodes();
      gaps_on = 1'b1;
      test_exception_return();
      test_psr_transfer_words();
      wait_for_retires();
      test_random_stream();

      wait_for_retires();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
rtl/dps_pkg.sv
rtl/dps_shifter.sv
rtl/dps_alu.sv
rtl/data_processing_alu_shifter.sv
sim/tb_data_processing_alu_shifter.sv
